// File: hdl/light_irradiance_eval_top_defines.svh
// Assertion helpers for the light irradiance block.
`ifndef LIGHT_IRRADIANCE_EVAL_TOP_DEFINES_SVH
`define LIGHT_IRRADIANCE_EVAL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define LIE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define LIE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LIE_ASSERT(lbl, prop, msg)
`define LIE_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/lie_pkg.sv
package lie_pkg;

	// field widths
	localparam int COORD_BITS = 20;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int DIR_BITS   = 16;
	localparam int IRR_BITS   = 16;
	localparam int OUT_BITS   = 24;
	localparam int ANG_BITS   = 16;

	// distance and dot product
	localparam int LEN_BITS  = 2 * DIFF_BITS;
	localparam int PROD_BITS = DIR_BITS + DIFF_BITS;
	localparam int DOT_BITS  = PROD_BITS + 2;
	localparam int MAG_BITS  = DOT_BITS - 1;
	localparam int ROOT_BITS = LEN_BITS / 2;
	localparam int RT_STEPS  = LEN_BITS / 2;

	// cosine and sine
	localparam int CD_STEPS = MAG_BITS;
	localparam int CM_BITS  = 15;
	localparam int COS_BITS = 16;
	localparam int ONE_Q14  = 16384;
	localparam int ARG_BITS = 29;
	localparam int AS_STEPS = (ARG_BITS + 1) / 2;
	localparam int YS_BITS  = 15;

	// angle
	localparam int CW            = 26;
	localparam int ZW            = 19;
	localparam int ANGLE_STEPS   = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int CORDIC_STEPS  = (ANGLE_STEPS < ATAN_ENTRIES) ? ANGLE_STEPS : ATAN_ENTRIES;
	localparam int HALF_PI_Q15   = 51472;
	localparam int ANGLE_MIN     = 33;
	localparam int ANGLE_MAX     = 32768;

	// attenuation and final quotient
	localparam int ATT_BITS = 17;
	localparam int ATT_ONE  = 65536;
	localparam int AQ_BITS  = 16;
	localparam int AD_STEPS = AQ_BITS;
	localparam int NUM_BITS = IRR_BITS + ATT_BITS;
	localparam int FD_STEPS = NUM_BITS;

	// total latency in stages
	localparam int DEPTH = 3 + RT_STEPS + CD_STEPS + 1 + AS_STEPS + 1 + CORDIC_STEPS + 1
		+ AD_STEPS + 1 + FD_STEPS + 1;

	// configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 3 * COORD_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_KIND, REG_POSITION, REG_DIRECTION, REG_IRRADIANCE, REG_OUTER, REG_FALLOFF
	} cfg_reg_t;

	typedef enum logic [1:0] {LK_DIRECTIONAL, LK_POINT, LK_SPOT} light_kind_t;

	typedef enum logic [1:0] {AC_ZERO, AC_ONE, AC_DIV} att_code_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic [3*COORD_BITS-1:0]  position;
		logic [3*DIR_BITS-1:0]    direction;
		logic [3*IRR_BITS-1:0]    irradiance;
		logic [ANG_BITS-1:0]      outer;
		logic [ANG_BITS-1:0]      falloff;
	} light_cfg_t;

	// arctan(2^-i) in Q1.15 radians
	function automatic logic [15:0] atan_q15(input int i);
		case (i)
			0:       atan_q15 = 16'd25736;
			1:       atan_q15 = 16'd15193;
			2:       atan_q15 = 16'd8027;
			3:       atan_q15 = 16'd4075;
			4:       atan_q15 = 16'd2045;
			5:       atan_q15 = 16'd1024;
			6:       atan_q15 = 16'd512;
			7:       atan_q15 = 16'd256;
			8:       atan_q15 = 16'd128;
			9:       atan_q15 = 16'd64;
			10:      atan_q15 = 16'd32;
			11:      atan_q15 = 16'd16;
			12:      atan_q15 = 16'd8;
			13:      atan_q15 = 16'd4;
			14:      atan_q15 = 16'd2;
			15:      atan_q15 = 16'd1;
			default: atan_q15 = 16'd0;
		endcase
	endfunction

endpackage

// File: hdl/light_irradiance_eval_top.sv
// Irradiance from one configured light at a stream of receiver points.
// Receiver channel: rcv_valid / rcv_stall, one point (x, y, z, signed Q12.8)
// per beat. Result channel: res_valid / res_stall, red, green, blue
// (unsigned Q16.8) and the saturated flag, one result beat per point, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; always
// ready. Write only while no point is in flight.
// Throughput is one point per cycle unless the result beat is stalled. The
// pipeline has a 21-stage square root of the distance, a 38-stage divider for the
// cosine, a 15-stage sine root, 16 rotation stages for the angle, a 16-stage
// falloff divider and a 33-stage divider by the squared distance.
// When the result beat is stalled the whole pipeline holds and rcv_stall rises;
// nothing is dropped or repeated. Reset clears all valid bits and loads the
// register defaults: directional light, zero position, direction and
// irradiance, both cone angles at one radian.
`include "light_irradiance_eval_top_defines.svh"

module light_irradiance_eval_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rcv_valid,
	output logic                                  rcv_stall,
	input  logic signed [lie_pkg::COORD_BITS-1:0] receiver_x,
	input  logic signed [lie_pkg::COORD_BITS-1:0] receiver_y,
	input  logic signed [lie_pkg::COORD_BITS-1:0] receiver_z,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic [lie_pkg::OUT_BITS-1:0]          red_out,
	output logic [lie_pkg::OUT_BITS-1:0]          green_out,
	output logic [lie_pkg::OUT_BITS-1:0]          blue_out,
	output logic                                  saturated,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lie_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [lie_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import lie_pkg::*;

	light_cfg_t cfg_q;
	logic       en;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind       <= LK_DIRECTIONAL;
			cfg_q.position   <= '0;
			cfg_q.direction  <= '0;
			cfg_q.irradiance <= '0;
			cfg_q.outer      <= ANG_BITS'(ANGLE_MAX);
			cfg_q.falloff    <= ANG_BITS'(ANGLE_MAX);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KIND:       cfg_q.kind       <= cfg_data[1:0];
				REG_POSITION:   cfg_q.position   <= cfg_data[3*COORD_BITS-1:0];
				REG_DIRECTION:  cfg_q.direction  <= cfg_data[3*DIR_BITS-1:0];
				REG_IRRADIANCE: cfg_q.irradiance <= cfg_data[3*IRR_BITS-1:0];
				REG_OUTER:      cfg_q.outer      <= cfg_data[ANG_BITS-1:0];
				REG_FALLOFF:    cfg_q.falloff    <= cfg_data[ANG_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// pipeline advances unless the result beat is held
	assign en        = !(res_valid && res_stall);
	assign rcv_stall = !en;

	lie_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.rcv_valid (rcv_valid),
		.rcv_x     (receiver_x),
		.rcv_y     (receiver_y),
		.rcv_z     (receiver_z),
		.res_valid (res_valid),
		.res_r     (red_out),
		.res_g     (green_out),
		.res_b     (blue_out),
		.res_sat   (saturated)
	);

	localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

	// checks
	`LIE_ASSERT(a_dir_pass, res_valid && cfg_q.kind != LK_POINT && cfg_q.kind != LK_SPOT |-> !saturated && red_out == OUT_BITS'(cfg_q.irradiance[IRR_BITS-1:0]), "directional light must pass irradiance")
	`LIE_ASSERT(a_dark_red, res_valid && cfg_q.irradiance[IRR_BITS-1:0] == '0 |-> red_out == '0, "zero red irradiance gave light")
	`LIE_ASSERT(a_sat_max, res_valid && saturated |-> red_out == OUT_MAX || green_out == OUT_MAX || blue_out == OUT_MAX || cfg_q.irradiance == '0, "saturated without a clipped channel")
	`LIE_NEVER(a_stall_idle, rcv_stall && !res_valid, "input stalled with no result waiting")

endmodule

// File: hdl/lie_core.sv
module lie_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  lie_pkg::light_cfg_t               cfg,
	input  logic                              rcv_valid,
	input  logic signed [lie_pkg::COORD_BITS-1:0] rcv_x,
	input  logic signed [lie_pkg::COORD_BITS-1:0] rcv_y,
	input  logic signed [lie_pkg::COORD_BITS-1:0] rcv_z,
	output logic                              res_valid,
	output logic [lie_pkg::OUT_BITS-1:0]      res_r,
	output logic [lie_pkg::OUT_BITS-1:0]      res_g,
	output logic [lie_pkg::OUT_BITS-1:0]      res_b,
	output logic                              res_sat
);
	import lie_pkg::*;

	localparam int RW = LEN_BITS + 1;
	localparam int AW = ARG_BITS + 1;
	localparam int NW = ZW + 1;

	// unpacked views of the receiver and config fields
	logic signed [COORD_BITS-1:0] rc [3];
	logic signed [COORD_BITS-1:0] pc [3];
	logic signed [DIR_BITS-1:0]   dc [3];
	logic [IRR_BITS-1:0]          ic [3];

	assign rc[0] = rcv_x;
	assign rc[1] = rcv_y;
	assign rc[2] = rcv_z;

	for (genvar k = 0; k < 3; k++) begin : g_fld
		assign pc[k] = cfg.position[k*COORD_BITS +: COORD_BITS];
		assign dc[k] = cfg.direction[k*DIR_BITS +: DIR_BITS];
		assign ic[k] = cfg.irradiance[k*IRR_BITS +: IRR_BITS];
	end

	// valid bits, one per stage
	logic [DEPTH:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-1:1], rcv_valid};
		end
	end

	assign res_valid = vld_s[DEPTH];

	// stage 1: offset from the light
	logic signed [DIFF_BITS-1:0] d_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= DIFF_BITS'(rc[k]) - DIFF_BITS'(pc[k]);
			end
		end
	end

	// stage 2: squares and direction products
	logic signed [LEN_BITS-1:0]  dw_c [3];
	logic signed [PROD_BITS-1:0] dp_c [3];
	logic signed [PROD_BITS-1:0] dd_c [3];
	logic [LEN_BITS-1:0]         sq_s2 [3];
	logic signed [PROD_BITS-1:0] pr_s2 [3];

	for (genvar k = 0; k < 3; k++) begin : g_ext
		assign dw_c[k] = LEN_BITS'(d_s1[k]);
		assign dp_c[k] = PROD_BITS'(d_s1[k]);
		assign dd_c[k] = PROD_BITS'(dc[k]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= dw_c[k] * dw_c[k];
				pr_s2[k] <= dp_c[k] * dd_c[k];
			end
		end
	end

	// stage 3: squared length and dot magnitude
	logic signed [DOT_BITS-1:0] dot_c;
	logic [DOT_BITS-1:0]        dabs_c;
	logic [LEN_BITS-1:0]        len_s3;
	logic [MAG_BITS-1:0]        mag_s3;
	logic                       neg_s3;

	assign dot_c  = DOT_BITS'(pr_s2[0]) + DOT_BITS'(pr_s2[1]) + DOT_BITS'(pr_s2[2]);
	assign dabs_c = dot_c[DOT_BITS-1] ? DOT_BITS'(-dot_c) : DOT_BITS'(dot_c);

	always_ff @(posedge clk) begin
		if (en) begin
			len_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			mag_s3 <= dabs_c[MAG_BITS-1:0];
			neg_s3 <= dot_c[DOT_BITS-1];
		end
	end

	// square root of the length, two bits a stage
	logic [RW-1:0]       rt_rem_s  [RT_STEPS+1];
	logic [RW-1:0]       rt_root_s [RT_STEPS+1];
	logic [LEN_BITS-1:0] rt_len_s  [RT_STEPS+1];
	logic [MAG_BITS-1:0] rt_mag_s  [RT_STEPS+1];
	logic                rt_neg_s  [RT_STEPS+1];

	assign rt_rem_s[0]  = RW'(len_s3);
	assign rt_root_s[0] = '0;
	assign rt_len_s[0]  = len_s3;
	assign rt_mag_s[0]  = mag_s3;
	assign rt_neg_s[0]  = neg_s3;

	for (genvar j = 0; j < RT_STEPS; j++) begin : g_rt
		localparam logic [RW-1:0] BITV = RW'(1) << (2 * (RT_STEPS - 1 - j));
		logic [RW-1:0] trial;
		assign trial = rt_root_s[j] + BITV;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rt_rem_s[j] >= trial) begin
					rt_rem_s[j+1]  <= rt_rem_s[j] - trial;
					rt_root_s[j+1] <= (rt_root_s[j] >> 1) + BITV;
				end else begin
					rt_rem_s[j+1]  <= rt_rem_s[j];
					rt_root_s[j+1] <= rt_root_s[j] >> 1;
				end
				rt_len_s[j+1] <= rt_len_s[j];
				rt_mag_s[j+1] <= rt_mag_s[j];
				rt_neg_s[j+1] <= rt_neg_s[j];
			end
		end
	end

	// dot magnitude over distance, one quotient bit a stage
	logic [ROOT_BITS-1:0] cd_rem_s [CD_STEPS+1];
	logic [MAG_BITS-1:0]  cd_q_s   [CD_STEPS+1];
	logic [MAG_BITS-1:0]  cd_num_s [CD_STEPS+1];
	logic [ROOT_BITS-1:0] cd_den_s [CD_STEPS+1];
	logic [LEN_BITS-1:0]  cd_len_s [CD_STEPS+1];
	logic                 cd_neg_s [CD_STEPS+1];

	assign cd_rem_s[0] = '0;
	assign cd_q_s[0]   = '0;
	assign cd_num_s[0] = rt_mag_s[RT_STEPS];
	assign cd_den_s[0] = rt_root_s[RT_STEPS][ROOT_BITS-1:0];
	assign cd_len_s[0] = rt_len_s[RT_STEPS];
	assign cd_neg_s[0] = rt_neg_s[RT_STEPS];

	for (genvar j = 0; j < CD_STEPS; j++) begin : g_cd
		logic [ROOT_BITS:0] t;
		logic               ge;
		assign t  = {cd_rem_s[j], cd_num_s[j][MAG_BITS-1]};
		assign ge = t >= {1'b0, cd_den_s[j]};
		always_ff @(posedge clk) begin
			if (en) begin
				cd_rem_s[j+1] <= ge ? ROOT_BITS'(t - {1'b0, cd_den_s[j]}) : ROOT_BITS'(t);
				cd_q_s[j+1]   <= {cd_q_s[j][MAG_BITS-2:0], ge};
				cd_num_s[j+1] <= cd_num_s[j] << 1;
				cd_den_s[j+1] <= cd_den_s[j];
				cd_len_s[j+1] <= cd_len_s[j];
				cd_neg_s[j+1] <= cd_neg_s[j];
			end
		end
	end

	// stage 63: clamped cosine and 1 - c^2
	localparam logic [ARG_BITS-1:0] ARG_ONE = ARG_BITS'(1) << (ARG_BITS - 1);

	logic [CM_BITS-1:0]         cm_c;
	logic [ARG_BITS-1:0]        csq_c;
	logic signed [COS_BITS-1:0] cpos_c;
	logic signed [COS_BITS-1:0] c_s63;
	logic [ARG_BITS-1:0]        arg_s63;
	logic [LEN_BITS-1:0]        len_s63;

	assign cm_c   = (cd_q_s[CD_STEPS] > MAG_BITS'(ONE_Q14)) ? CM_BITS'(ONE_Q14)
		: cd_q_s[CD_STEPS][CM_BITS-1:0];
	assign csq_c  = ARG_BITS'(cm_c) * ARG_BITS'(cm_c);
	assign cpos_c = COS_BITS'(cm_c);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s63   <= cd_neg_s[CD_STEPS] ? -cpos_c : cpos_c;
			arg_s63 <= ARG_ONE - csq_c;
			len_s63 <= cd_len_s[CD_STEPS];
		end
	end

	// sine magnitude, two bits a stage
	logic [AW-1:0]              as_rem_s  [AS_STEPS+1];
	logic [AW-1:0]              as_root_s [AS_STEPS+1];
	logic signed [COS_BITS-1:0] as_c_s    [AS_STEPS+1];
	logic [LEN_BITS-1:0]        as_len_s  [AS_STEPS+1];

	assign as_rem_s[0]  = AW'(arg_s63);
	assign as_root_s[0] = '0;
	assign as_c_s[0]    = c_s63;
	assign as_len_s[0]  = len_s63;

	for (genvar j = 0; j < AS_STEPS; j++) begin : g_as
		localparam logic [AW-1:0] BITV = AW'(1) << (2 * (AS_STEPS - 1 - j));
		logic [AW-1:0] trial;
		assign trial = as_root_s[j] + BITV;
		always_ff @(posedge clk) begin
			if (en) begin
				if (as_rem_s[j] >= trial) begin
					as_rem_s[j+1]  <= as_rem_s[j] - trial;
					as_root_s[j+1] <= (as_root_s[j] >> 1) + BITV;
				end else begin
					as_rem_s[j+1]  <= as_rem_s[j];
					as_root_s[j+1] <= as_root_s[j] >> 1;
				end
				as_c_s[j+1]   <= as_c_s[j];
				as_len_s[j+1] <= as_len_s[j];
			end
		end
	end

	// stage 79: scale up, pre-rotate the left half plane by 90 degrees
	logic signed [CW-1:0] x0_c;
	logic signed [CW-1:0] y0_c;
	logic signed [CW-1:0] cr_x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] cr_y_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] cr_z_s [CORDIC_STEPS+1];
	logic [LEN_BITS-1:0]  cr_len_s [CORDIC_STEPS+1];

	assign x0_c = CW'(as_c_s[AS_STEPS]) <<< 8;
	assign y0_c = signed'(CW'(as_root_s[AS_STEPS][YS_BITS-1:0])) <<< 8;

	always_ff @(posedge clk) begin
		if (en) begin
			if (as_c_s[AS_STEPS] < 0) begin
				cr_x_s[0] <= y0_c;
				cr_y_s[0] <= -x0_c;
				cr_z_s[0] <= ZW'(HALF_PI_Q15);
			end else begin
				cr_x_s[0] <= x0_c;
				cr_y_s[0] <= y0_c;
				cr_z_s[0] <= '0;
			end
			cr_len_s[0] <= as_len_s[AS_STEPS];
		end
	end

	// vectoring rotations, one per stage
	for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cr
		localparam logic signed [ZW-1:0] ATV = ZW'(atan_q15(j));
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		assign xs = cr_x_s[j] >>> j;
		assign ys = cr_y_s[j] >>> j;
		always_ff @(posedge clk) begin
			if (en) begin
				if (cr_y_s[j] > 0) begin
					cr_x_s[j+1] <= cr_x_s[j] + ys;
					cr_y_s[j+1] <= cr_y_s[j] - xs;
					cr_z_s[j+1] <= cr_z_s[j] + ATV;
				end else begin
					cr_x_s[j+1] <= cr_x_s[j] - ys;
					cr_y_s[j+1] <= cr_y_s[j] + xs;
					cr_z_s[j+1] <= cr_z_s[j] - ATV;
				end
				cr_len_s[j+1] <= cr_len_s[j];
			end
		end
	end

	// cone limits from the angle registers
	logic [ANG_BITS-1:0] o_c;
	logic [ANG_BITS-1:0] f_c;

	always_comb begin
		if (cfg.outer < ANG_BITS'(ANGLE_MIN)) begin
			o_c = ANG_BITS'(ANGLE_MIN);
		end else if (cfg.outer > ANG_BITS'(ANGLE_MAX)) begin
			o_c = ANG_BITS'(ANGLE_MAX);
		end else begin
			o_c = cfg.outer;
		end
		if (cfg.falloff < ANG_BITS'(ANGLE_MIN)) begin
			f_c = ANG_BITS'(ANGLE_MIN);
		end else if (cfg.falloff > o_c) begin
			f_c = o_c;
		end else begin
			f_c = cfg.falloff;
		end
	end

	// stage 96: margin inside the cone and its class
	logic signed [NW-1:0] n_c;
	logic [AQ_BITS-1:0]   n_s96;
	att_code_t            code_s96;
	logic [LEN_BITS-1:0]  len_s96;

	assign n_c = signed'(NW'(o_c)) - NW'(cr_z_s[CORDIC_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (n_c <= 0) begin
				code_s96 <= AC_ZERO;
			end else if (n_c >= signed'(NW'(f_c))) begin
				code_s96 <= AC_ONE;
			end else begin
				code_s96 <= AC_DIV;
			end
			n_s96   <= n_c[AQ_BITS-1:0];
			len_s96 <= cr_len_s[CORDIC_STEPS];
		end
	end

	// margin over falloff width as a Q0.16 fraction
	logic [AQ_BITS-1:0]  ad_rem_s  [AD_STEPS+1];
	logic [AQ_BITS-1:0]  ad_q_s    [AD_STEPS+1];
	att_code_t           ad_code_s [AD_STEPS+1];
	logic [LEN_BITS-1:0] ad_len_s  [AD_STEPS+1];

	assign ad_rem_s[0]  = n_s96;
	assign ad_q_s[0]    = '0;
	assign ad_code_s[0] = code_s96;
	assign ad_len_s[0]  = len_s96;

	for (genvar j = 0; j < AD_STEPS; j++) begin : g_ad
		logic [AQ_BITS:0] t;
		logic             ge;
		assign t  = {ad_rem_s[j], 1'b0};
		assign ge = t >= {1'b0, f_c};
		always_ff @(posedge clk) begin
			if (en) begin
				ad_rem_s[j+1]  <= ge ? AQ_BITS'(t - {1'b0, f_c}) : AQ_BITS'(t);
				ad_q_s[j+1]    <= {ad_q_s[j][AQ_BITS-2:0], ge};
				ad_code_s[j+1] <= ad_code_s[j];
				ad_len_s[j+1]  <= ad_len_s[j];
			end
		end
	end

	// stage 113: irradiance times attenuation
	logic [ATT_BITS-1:0] att_c;
	logic [NUM_BITS-1:0] num_s113 [3];
	logic [LEN_BITS-1:0] len_s113;

	always_comb begin
		att_c = ATT_BITS'(ATT_ONE);
		if (cfg.kind == LK_SPOT) begin
			case (ad_code_s[AD_STEPS])
				AC_ZERO: att_c = '0;
				AC_ONE:  att_c = ATT_BITS'(ATT_ONE);
				AC_DIV:  att_c = ATT_BITS'(ad_q_s[AD_STEPS]);
				default: att_c = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s113[k] <= NUM_BITS'(ic[k]) * NUM_BITS'(att_c);
			end
			len_s113 <= ad_len_s[AD_STEPS];
		end
	end

	// each channel over the squared length, one quotient bit a stage
	logic [LEN_BITS-1:0] fd_rem_s [3][FD_STEPS+1];
	logic [NUM_BITS-1:0] fd_q_s   [3][FD_STEPS+1];
	logic [NUM_BITS-1:0] fd_num_s [3][FD_STEPS+1];
	logic [LEN_BITS-1:0] fd_len_s [FD_STEPS+1];

	assign fd_len_s[0] = len_s113;

	for (genvar j = 0; j < FD_STEPS; j++) begin : g_fdl
		always_ff @(posedge clk) begin
			if (en) begin
				fd_len_s[j+1] <= fd_len_s[j];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_ch
		assign fd_rem_s[k][0] = '0;
		assign fd_q_s[k][0]   = '0;
		assign fd_num_s[k][0] = num_s113[k];
		for (genvar j = 0; j < FD_STEPS; j++) begin : g_fd
			logic [LEN_BITS:0] t;
			logic              ge;
			assign t  = {fd_rem_s[k][j], fd_num_s[k][j][NUM_BITS-1]};
			assign ge = t >= {1'b0, fd_len_s[j]};
			always_ff @(posedge clk) begin
				if (en) begin
					fd_rem_s[k][j+1] <= ge ? LEN_BITS'(t - {1'b0, fd_len_s[j]}) : LEN_BITS'(t);
					fd_q_s[k][j+1]   <= {fd_q_s[k][j][NUM_BITS-2:0], ge};
					fd_num_s[k][j+1] <= fd_num_s[k][j] << 1;
				end
			end
		end
	end

	// stage 147: select by light kind, clip
	localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

	logic [2:0]          clip_c;
	logic [OUT_BITS-1:0] ch_s147 [3];
	logic                sat_s147;

	for (genvar k = 0; k < 3; k++) begin : g_clip
		assign clip_c[k] = fd_q_s[k][FD_STEPS] > NUM_BITS'(OUT_MAX);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cfg.kind != LK_POINT && cfg.kind != LK_SPOT) begin
				for (int k = 0; k < 3; k++) begin
					ch_s147[k] <= OUT_BITS'(ic[k]);
				end
				sat_s147 <= 1'b0;
			end else if (fd_len_s[FD_STEPS] == '0) begin
				for (int k = 0; k < 3; k++) begin
					ch_s147[k] <= (ic[k] != '0) ? OUT_MAX : '0;
				end
				sat_s147 <= 1'b1;
			end else begin
				for (int k = 0; k < 3; k++) begin
					ch_s147[k] <= clip_c[k] ? OUT_MAX : fd_q_s[k][FD_STEPS][OUT_BITS-1:0];
				end
				sat_s147 <= |clip_c;
			end
		end
	end

	assign res_r   = ch_s147[0];
	assign res_g   = ch_s147[1];
	assign res_b   = ch_s147[2];
	assign res_sat = sat_s147;

endmodule

// File: test/tb_light_irradiance_eval_top.sv
module tb_light_irradiance_eval_top;
	import lie_pkg::*;

	localparam int PIPE_LAT = 147;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic signed [COORD_BITS-1:0] x, y, z;
	} point_t;

	typedef struct {
		logic [OUT_BITS-1:0] r, g, b;
		logic                sat;
	} light_res_t;

	logic clk, arst_n;
	logic rcv_valid, rcv_stall, res_valid, res_stall;
	logic signed [COORD_BITS-1:0] receiver_x, receiver_y, receiver_z;
	logic [OUT_BITS-1:0] red_out, green_out, blue_out;
	logic saturated, cfg_valid, cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	light_irradiance_eval_top i_dut (.*);

	// shadow copy of the light registers
	logic [1:0]              sh_kind;
	logic [3*COORD_BITS-1:0] sh_pos;
	logic [3*DIR_BITS-1:0]   sh_dir;
	logic [3*IRR_BITS-1:0]   sh_irr;
	logic [15:0]             sh_outer, sh_fall;

	point_t     pending_pts[$];
	light_res_t expected_res[$];
	int errors = 0;
	longint cycles = 0;
	int hold_off = 0;
	bit long_hold_req = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;
	always @(posedge clk) if (cycles > CYCLE_LIMIT) begin
		$display("simulation failed");
		$finish;
	end

	function automatic longint unsigned isqrt_u(longint unsigned v);
		longint unsigned r = 0, bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v -= r + bt;
				r = (r >> 1) + bt;
			end else r >>= 1;
			bt >>= 2;
		end
		return r;
	endfunction

	// CORDIC angle of (x, y), y >= 0, Q1.15
	function automatic longint spot_angle(longint x, longint y);
		longint z = 0, t, xs, ys;
		if (x < 0) begin
			t = x; x = y; y = -t; z = HALF_PI_Q15;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z += longint'(atan_q15(i));
			end else begin
				x = x - ys; y = y + xs; z -= longint'(atan_q15(i));
			end
		end
		return z;
	endfunction

	function automatic light_res_t irradiance_at(point_t p);
		light_res_t res;
		longint d[3], dot, c, o, f, n, ang;
		longint unsigned irr[3], len2, att, mag, s, cm, v, m;
		logic signed [COORD_BITS-1:0] pv[3];
		pv[0] = p.x; pv[1] = p.y; pv[2] = p.z;
		len2 = 0; att = ATT_ONE; res.sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			irr[k] = sh_irr[k*IRR_BITS +: IRR_BITS];
			d[k] = longint'(pv[k]) -
				longint'($signed(sh_pos[k*COORD_BITS +: COORD_BITS]));
		end
		if (sh_kind != LK_POINT && sh_kind != LK_SPOT) begin
			res.r = OUT_BITS'(irr[0]); res.g = OUT_BITS'(irr[1]); res.b = OUT_BITS'(irr[2]);
			return res;
		end
		for (int k = 0; k < 3; k++) begin
			m = d[k] < 0 ? -d[k] : d[k];
			len2 += m * m;
		end
		// zero distance saturates every lit channel
		if (len2 == 0) begin
			res.r = irr[0] != 0 ? '1 : '0;
			res.g = irr[1] != 0 ? '1 : '0;
			res.b = irr[2] != 0 ? '1 : '0;
			res.sat = 1'b1;
			return res;
		end
		if (sh_kind == LK_SPOT) begin
			dot = 0;
			for (int k = 0; k < 3; k++)
				dot += longint'($signed(sh_dir[k*DIR_BITS +: DIR_BITS])) * d[k];
			s = isqrt_u(len2);
			mag = dot < 0 ? -dot : dot;
			cm = mag / s;
			if (cm > ONE_Q14) cm = ONE_Q14;
			c = dot < 0 ? -longint'(cm) : longint'(cm);
			ang = spot_angle(c * 256, longint'(isqrt_u((64'd1 << 28) - c * c)) * 256);
			o = sh_outer;
			if (o < ANGLE_MIN) o = ANGLE_MIN;
			if (o > ANGLE_MAX) o = ANGLE_MAX;
			f = sh_fall;
			if (f < ANGLE_MIN) f = ANGLE_MIN;
			if (f > o) f = o;
			n = o - ang;
			if (n <= 0) att = 0;
			else if (n >= f) att = ATT_ONE;
			else att = (longint'(n) << 16) / f;
		end
		for (int k = 0; k < 3; k++) begin
			v = irr[k] * att / len2;
			if (v > 64'hFFFFFF) begin
				v = 64'hFFFFFF; res.sat = 1'b1;
			end
			if (k == 0) res.r = OUT_BITS'(v);
			else if (k == 1) res.g = OUT_BITS'(v);
			else res.b = OUT_BITS'(v);
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic int gap_len();
		int r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver driver; prediction taken at acceptance
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_valid <= 0;
			receiver_x <= '0; receiver_y <= '0; receiver_z <= '0;
		end else begin
			if (rcv_valid && !rcv_stall) begin
				expected_res.push_back(irradiance_at('{receiver_x, receiver_y, receiver_z}));
				void'(pending_pts.pop_front());
				src_gap = gap_len();
			end
			if (rcv_valid && rcv_stall) begin
				// hold beat
			end else if (src_gap > 0 || pending_pts.size() == 0) begin
				if (src_gap > 0) src_gap--;
				rcv_valid <= 0;
			end else begin
				rcv_valid <= 1;
				receiver_x <= pending_pts[0].x;
				receiver_y <= pending_pts[0].y;
				receiver_z <= pending_pts[0].z;
			end
		end
	end

	// result stall pattern, with an occasional long hold
	int sink_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 0;
			hold_off = 0;
		end else if (long_hold_req && hold_off == 0) begin
			long_hold_req = 0;
			hold_off = 400;
			res_stall <= 1;
		end else if (hold_off > 0) begin
			hold_off--;
			res_stall <= hold_off != 0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			res_stall <= 1;
		end else begin
			sink_gap = gap_len();
			res_stall <= 0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		light_res_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_res.size() == 0) begin
				$display("unexpected result beat at cycle %0d", cycles);
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (red_out !== e.r) report_mismatch("red", red_out, e.r);
				if (green_out !== e.g) report_mismatch("green", green_out, e.g);
				if (blue_out !== e.b) report_mismatch("blue", blue_out, e.b);
				if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_KIND:       sh_kind = val[1:0];
			REG_POSITION:   sh_pos = val;
			REG_DIRECTION:  sh_dir = val[47:0];
			REG_IRRADIANCE: sh_irr = val[47:0];
			REG_OUTER:      sh_outer = val[15:0];
			REG_FALLOFF:    sh_fall = val[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_pts.size() != 0 || rcv_valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	function automatic logic signed [COORD_BITS-1:0] rnd_coord(int mode);
		case (mode)
			0: return COORD_BITS'($urandom);
			1: return COORD_BITS'($signed(COORD_BITS'($urandom_range(0, 4095))) - 2048);
			default: return $urandom_range(0, 1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
				: {1'b1, {(COORD_BITS-1){1'b0}}};
		endcase
	endfunction

	function automatic logic [47:0] rnd_dir();
		logic [47:0] v;
		case ($urandom_range(0, 3))
			0: v = {$urandom, $urandom};
			1: v = {16'd0, 16'd0, 16'sd16384};
			2: v = {16'd0, -16'sd16384, 16'd0};
			default: v = {16'sd9459, -16'sd9459, 16'sd9459};
		endcase
		return v;
	endfunction

	task automatic random_points(int cnt, int near_light);
		point_t p;
		for (int i = 0; i < cnt; i++) begin
			int mode = $urandom_range(0, 9);
			if (near_light && mode < 6) begin
				p.x = $signed(sh_pos[0 +: COORD_BITS]) + $signed(12'($urandom)) ;
				p.y = $signed(sh_pos[COORD_BITS +: COORD_BITS]) + $signed(12'($urandom));
				p.z = $signed(sh_pos[2*COORD_BITS +: COORD_BITS]) + $signed(12'($urandom));
				if (mode == 0) begin
					p.x = sh_pos[0 +: COORD_BITS];
					p.y = sh_pos[COORD_BITS +: COORD_BITS];
					p.z = sh_pos[2*COORD_BITS +: COORD_BITS];
				end
			end else begin
				p.x = rnd_coord(mode % 3);
				p.y = rnd_coord((mode + 1) % 3);
				p.z = rnd_coord(mode / 4);
			end
			pending_pts.push_back(p);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0; cfg_index = REG_KIND; cfg_data = '0;
		sh_kind = LK_DIRECTIONAL; sh_pos = '0; sh_dir = '0; sh_irr = '0;
		sh_outer = ANGLE_MAX; sh_fall = ANGLE_MAX;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset defaults, then extremes per light kind
		pending_pts.push_back('{20'sd0, 20'sd0, 20'sd0});
		drain();
		write_reg(REG_IRRADIANCE, 48'hFFFF_0100_0000);
		pending_pts.push_back('{20'sh7FFFF, 20'sh80000, 20'sd1});
		drain();
		write_reg(REG_KIND, LK_POINT);
		pending_pts.push_back('{20'sd0, 20'sd0, 20'sd0});
		pending_pts.push_back('{20'sd1, 20'sd0, 20'sd0});
		pending_pts.push_back('{20'sd256, 20'sd0, 20'sd0});
		pending_pts.push_back('{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF});
		drain();
		write_reg(REG_POSITION, {20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF});
		pending_pts.push_back('{20'sh80000, 20'sh80000, 20'sh80000});
		pending_pts.push_back('{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF});
		drain();
		write_reg(REG_KIND, LK_SPOT);
		write_reg(REG_POSITION, '0);
		write_reg(REG_DIRECTION, {16'd0, 16'd0, 16'sd16384});
		write_reg(REG_OUTER, 16'd8000);
		write_reg(REG_FALLOFF, 16'd4000);
		pending_pts.push_back('{20'sd512, 20'sd0, 20'sd0});
		pending_pts.push_back('{20'sd512, 20'sd100, 20'sd0});
		pending_pts.push_back('{20'sd512, 20'sd600, 20'sd0});
		pending_pts.push_back('{-20'sd512, 20'sd0, 20'sd0});
		pending_pts.push_back('{20'sd0, 20'sd0, 20'sd0});
		drain();
		// out-of-range angles and a non-unit direction
		write_reg(REG_OUTER, 16'hFFFF);
		write_reg(REG_FALLOFF, 16'd0);
		write_reg(REG_DIRECTION, 48'h7FFF_7FFF_7FFF);
		pending_pts.push_back('{20'sd300, 20'sd300, 20'sd300});
		pending_pts.push_back('{-20'sd300, 20'sd5, 20'sd9});
		drain();
		write_reg(REG_OUTER, 16'd0);
		write_reg(REG_FALLOFF, 16'd40000);
		pending_pts.push_back('{20'sd300, 20'sd300, 20'sd300});
		drain();
		write_reg(REG_KIND, 2'd3);
		pending_pts.push_back('{20'sd7, 20'sd7, 20'sd7});
		drain();

		// random phases over varied settings
		for (int ph = 0; ph < 14; ph++) begin
			write_reg(REG_KIND, ph % 7 == 6 ? 2'd3 : ph % 3);
			write_reg(REG_POSITION, {$urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, 4095)),
				20'($urandom), 20'($urandom)});
			write_reg(REG_DIRECTION, rnd_dir());
			write_reg(REG_IRRADIANCE, ph == 3 ? 48'hFFFF_FFFF_FFFF : {$urandom, $urandom});
			write_reg(REG_OUTER, ph == 5 ? 16'd33 : ph == 8 ? 16'd32768 : 16'($urandom_range(20, 40000)));
			write_reg(REG_FALLOFF, ph == 5 ? 16'd33 : 16'($urandom_range(0, 40000)));
			if (ph == 4) long_hold_req = 1;
			random_points(100, 1);
			drain();
		end

		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule

// File: files.f
+incdir+hdl
hdl/lie_pkg.sv
hdl/lie_core.sv
hdl/light_irradiance_eval_top.sv
test/tb_light_irradiance_eval_top.sv
